@@ rtl/bced_pkg.sv @@
// ============================================================================
// bced_pkg - shared types and constants for the button click event detector
// Holds the state codes, listen event codes and register map.
// ============================================================================
package bced_pkg;

    // Button state codes, as reported on button_state
    typedef enum logic [3:0] {
        ST_OPEN     = 4'd0,
        ST_DEBOUNCE = 4'd1,
        ST_PRESS    = 4'd2,
        ST_LONG     = 4'd3,
        ST_STUCK    = 4'd4,
        ST_CLICK    = 4'd5,
        ST_DOUBLE   = 4'd6,
        ST_RELEASE  = 4'd7,
        ST_ACTION   = 4'd8
    } btn_state_t;

    // Code that matches no state; used for listen events out of range
    localparam logic [3:0] STATE_NONE = 4'd15;

    // Listen event codes
    localparam logic [2:0] EVT_PRESS   = 3'd0;
    localparam logic [2:0] EVT_LONG    = 3'd1;
    localparam logic [2:0] EVT_CLICK   = 3'd2;
    localparam logic [2:0] EVT_DOUBLE  = 3'd3;
    localparam logic [2:0] EVT_RELEASE = 3'd4;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_ACTIVE_LEVEL = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE_MS  = 3'd1;
    localparam logic [2:0] REG_HOLD_MS      = 3'd2;
    localparam logic [2:0] REG_DCLICK_MS    = 3'd3;
    localparam logic [2:0] REG_RELEASE_MS   = 3'd4;
    localparam logic [2:0] REG_LISTEN_EVENT = 3'd5;

    localparam int PADDR_WIDTH = 5;
    localparam int PDATA_WIDTH = 32;

    // Reset values of the configuration registers
    localparam logic        RST_ACTIVE_LEVEL = 1'b0;
    localparam logic [15:0] RST_DEBOUNCE_MS  = 16'd50;
    localparam logic [15:0] RST_HOLD_MS      = 16'd1000;
    localparam logic [15:0] RST_DCLICK_MS    = 16'd300;
    localparam logic [15:0] RST_RELEASE_MS   = 16'd50;
    localparam logic [2:0]  RST_LISTEN_EVENT = EVT_CLICK;

    // Map a listen event to the state whose exit into take action reports it
    function automatic logic [3:0] event_state(input logic [2:0] evt);
        logic [3:0] code;
        case (evt)
            EVT_PRESS:   code = ST_PRESS;
            EVT_LONG:    code = ST_LONG;
            EVT_CLICK:   code = ST_CLICK;
            EVT_DOUBLE:  code = ST_DOUBLE;
            EVT_RELEASE: code = ST_RELEASE;
            default:     code = STATE_NONE;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/button_click_event_detector.sv @@
// ============================================================================
// button_click_event_detector - push-button debounce and click classifier
// Tracks a polled button through debounce, press, long press, click, double
// click and release, and flags the configured event.
// ============================================================================
//
// Each input transaction is one poll of the button: the sampled pin level and
// a free-running millisecond time. Every poll produces exactly one output
// transaction carrying the state after the poll and a flag that is high when
// the configured listen event is reported. The block takes one poll per clock
// cycle: a poll is held in the input register, the state machine update
// (a TIME_WIDTH-bit wrapping subtract and four compares against the 16-bit
// thresholds) sits between that register and the result register, which
// offers the result on out_valid. A result that waits for out_ready holds the
// input register as well, so in_ready drops once both registers are full;
// with out_ready high a poll is taken every cycle. Configuration lives in an
// APB-style register file (byte addresses 0x00..0x14) and should be written
// only while no poll is in flight.

module button_click_event_detector #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bced_pkg::PADDR_WIDTH-1:0]   paddr,
    input  logic [bced_pkg::PDATA_WIDTH-1:0]   pwdata,
    output logic [bced_pkg::PDATA_WIDTH-1:0]   prdata,
    output logic                               pready,

    // Poll input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               pin_level,
    input  logic [31:0]                        now_ms,

    // Result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               event_fired,
    output logic [3:0]                         button_state
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        active_level_reg;
    logic [15:0] debounce_ms_reg;
    logic [15:0] hold_ms_reg;
    logic [15:0] dclick_ms_reg;
    logic [15:0] release_ms_reg;
    logic [2:0]  listen_event_reg;

    logic        cfg_write;
    logic [2:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[bced_pkg::PADDR_WIDTH-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg <= bced_pkg::RST_ACTIVE_LEVEL;
            debounce_ms_reg  <= bced_pkg::RST_DEBOUNCE_MS;
            hold_ms_reg      <= bced_pkg::RST_HOLD_MS;
            dclick_ms_reg    <= bced_pkg::RST_DCLICK_MS;
            release_ms_reg   <= bced_pkg::RST_RELEASE_MS;
            listen_event_reg <= bced_pkg::RST_LISTEN_EVENT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bced_pkg::REG_ACTIVE_LEVEL: active_level_reg <= pwdata[0];
                bced_pkg::REG_DEBOUNCE_MS:  debounce_ms_reg  <= pwdata[15:0];
                bced_pkg::REG_HOLD_MS:      hold_ms_reg      <= pwdata[15:0];
                bced_pkg::REG_DCLICK_MS:    dclick_ms_reg    <= pwdata[15:0];
                bced_pkg::REG_RELEASE_MS:   release_ms_reg   <= pwdata[15:0];
                bced_pkg::REG_LISTEN_EVENT: listen_event_reg <= pwdata[2:0];
                default:                    ; // ignore writes beyond the map
            endcase
        end
    end

    // Read back: zero-extend each register into the data bus
    always_comb
    begin
        case (cfg_index)
            bced_pkg::REG_ACTIVE_LEVEL:
                prdata = bced_pkg::PDATA_WIDTH'(active_level_reg);
            bced_pkg::REG_DEBOUNCE_MS:
                prdata = bced_pkg::PDATA_WIDTH'(debounce_ms_reg);
            bced_pkg::REG_HOLD_MS:
                prdata = bced_pkg::PDATA_WIDTH'(hold_ms_reg);
            bced_pkg::REG_DCLICK_MS:
                prdata = bced_pkg::PDATA_WIDTH'(dclick_ms_reg);
            bced_pkg::REG_RELEASE_MS:
                prdata = bced_pkg::PDATA_WIDTH'(release_ms_reg);
            bced_pkg::REG_LISTEN_EVENT:
                prdata = bced_pkg::PDATA_WIDTH'(listen_event_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    // The input register advances into the result register whenever the
    // result register is empty or its transaction is being taken.
    logic        in_valid_reg;
    logic        in_pin_reg;
    logic [31:0] in_now_reg;
    logic        out_valid_reg;
    logic        event_fired_reg;
    logic [3:0]  button_state_reg;
    logic        advance;

    assign advance  = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Payload holds while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (in_ready & in_valid)
        begin
            in_pin_reg <= pin_level;
            in_now_reg <= now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Button state machine
    // ------------------------------------------------------------------
    bced_pkg::btn_state_t    current_state_reg, current_state_next;
    bced_pkg::btn_state_t    previous_state_reg;
    logic [TIME_WIDTH-1:0]   last_change_reg;
    logic [TIME_WIDTH-1:0]   now_w;
    logic [TIME_WIDTH-1:0]   elapsed;
    logic [3:0]              want;
    logic                    pressed;
    logic                    fired_next;
    logic                    debounce_met;
    logic                    long_met;
    logic                    dclick_met;
    logic                    release_met;

    // Cut or extend the poll time to the tracked width; elapsed wraps.
    assign now_w    = TIME_WIDTH'(in_now_reg);
    assign elapsed  = now_w - last_change_reg;
    assign pressed  = (in_pin_reg == active_level_reg);
    assign want     = bced_pkg::event_state(listen_event_reg);

    assign debounce_met = elapsed >= TIME_WIDTH'(debounce_ms_reg);
    assign long_met     = elapsed >= TIME_WIDTH'(hold_ms_reg);
    assign dclick_met   = elapsed >= TIME_WIDTH'(dclick_ms_reg);
    assign release_met  = elapsed >  TIME_WIDTH'(release_ms_reg);

    always_comb
    begin
        current_state_next = current_state_reg;
        fired_next         = 1'b0;
        case (current_state_reg)
            bced_pkg::ST_OPEN:
            begin
                if (pressed)
                    current_state_next = bced_pkg::ST_DEBOUNCE;
            end
            bced_pkg::ST_DEBOUNCE:
            begin
                if (!pressed)
                    current_state_next = bced_pkg::ST_OPEN;
                else if (debounce_met)
                    current_state_next = bced_pkg::ST_PRESS;
            end
            bced_pkg::ST_PRESS:
            begin
                // Listening for a plain press: go to take action at once
                if (want == 4'(bced_pkg::ST_PRESS))
                    current_state_next = bced_pkg::ST_ACTION;
                else if (!pressed)
                    current_state_next = bced_pkg::ST_CLICK;
                else if (long_met)
                    current_state_next = bced_pkg::ST_LONG;
            end
            bced_pkg::ST_LONG:
            begin
                // A release on the same poll wins over take action
                if (!pressed)
                    current_state_next = bced_pkg::ST_RELEASE;
                else if (want == 4'(bced_pkg::ST_LONG))
                    current_state_next = bced_pkg::ST_ACTION;
            end
            bced_pkg::ST_STUCK:
            begin
                if (!pressed)
                    current_state_next = bced_pkg::ST_RELEASE;
            end
            bced_pkg::ST_CLICK:
            begin
                if (!pressed && dclick_met)
                    current_state_next = bced_pkg::ST_ACTION;
                else if (pressed && !dclick_met && debounce_met)
                    current_state_next = bced_pkg::ST_DOUBLE;
            end
            bced_pkg::ST_DOUBLE,
            bced_pkg::ST_RELEASE:
            begin
                current_state_next = bced_pkg::ST_ACTION;
            end
            bced_pkg::ST_ACTION:
            begin
                // Report when the state that led here is the one listened for
                if (release_met)
                begin
                    fired_next         = (4'(previous_state_reg) == want);
                    current_state_next = pressed ? bced_pkg::ST_STUCK
                                                 : bced_pkg::ST_OPEN;
                end
            end
            default:
            begin
                current_state_next = current_state_reg;
            end
        endcase
    end

    // Advance the state and the result register together; every transition
    // records the state left and the poll time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_state_reg  <= bced_pkg::ST_OPEN;
            previous_state_reg <= bced_pkg::ST_OPEN;
            last_change_reg    <= '0;
            out_valid_reg      <= 1'b0;
            event_fired_reg    <= 1'b0;
            button_state_reg   <= 4'(bced_pkg::ST_OPEN);
        end
        else
        begin
            if (advance)
            begin
                if (current_state_next != current_state_reg)
                begin
                    previous_state_reg <= current_state_reg;
                    current_state_reg  <= current_state_next;
                    last_change_reg    <= now_w;
                end
                event_fired_reg  <= fired_next;
                button_state_reg <= 4'(current_state_next);
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                // Drop the result once it is taken
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_fired  = event_fired_reg;
    assign button_state = button_state_reg;

endmodule
